[design/mbe_pkg.sv]
package mbe_pkg;

    localparam int MAX_N     = 4096;
    localparam int DEPTH     = MAX_N + 1;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int VAL_W     = 31;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int CNT_W     = $clog2(PROD_W);
    localparam int TOP_W     = 17;
    localparam logic [VAL_W-1:0] MOD_RESET = 31'd1000000007;

    typedef enum logic [1:0] {
        K_FACT = 2'd0,
        K_PERM = 2'd1,
        K_COMB = 2'd2,
        K_REP  = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECIDE,
        S_EXT,
        S_DIV,
        S_INV_RD,
        S_INV_MUL,
        S_INV_WR,
        S_FAC,
        S_FAC_WR,
        S_IFA,
        S_IFA_WR,
        S_QRD,
        S_QRD2,
        S_QM1,
        S_QM2,
        S_QM3,
        S_OUT
    } t_state;

endpackage

[design/modular_binomial_engine.sv]
// With the tables already covering the index, a factorial is a table read,
// permutations add one modular reduction and combinations two; results that
// need no lookup skip the tables. Missing table entries are computed first.
// One item at a time; the 62-step shift-subtract reducer sets the pace.
// A new item is taken only after the result handshake; ready only when idle.
// Reset (synchronous, active low): modulus 1000000007, tables empty.
module modular_binomial_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_count_n,
    input  logic [15:0] i_choose_k,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [30:0] o_value,
    output logic        o_out_of_range
);

    localparam int VW = mbe_pkg::VAL_W;
    localparam int PW = mbe_pkg::PROD_W;
    localparam int IW = mbe_pkg::IDX_W;

    mbe_pkg::t_state r_state, n_state, r_ret;

    logic [VW-1:0]  inv_mem  [mbe_pkg::DEPTH];
    logic [VW-1:0]  fac_mem  [mbe_pkg::DEPTH];
    logic [VW-1:0]  ifa_mem  [mbe_pkg::DEPTH];

    logic [VW-1:0]  r_mod;
    logic [IW-1:0]  r_filled;
    logic [1:0]     r_kind;
    logic [15:0]    r_k;
    logic [mbe_pkg::TOP_W-1:0] r_top;
    logic           r_zero;
    logic [VW-1:0]  r_val;
    logic           r_oor;
    logic [PW-1:0]  r_dvd;
    logic [VW-1:0]  r_rem;
    logic [VW-1:0]  r_dvs;
    logic [mbe_pkg::CNT_W-1:0] r_cnt;
    logic [VW-1:0]  r_q;
    logic [VW-1:0]  r_inv_q;
    logic [VW-1:0]  r_inv;
    logic [VW-1:0]  r_flast;
    logic [VW-1:0]  r_iflast;
    logic [VW-1:0]  r_fq, r_ia, r_ib;

    logic [VW:0]    rem_sh;
    logic           ge;
    logic [mbe_pkg::TOP_W-1:0] top_c;
    logic [mbe_pkg::TOP_W-1:0] k_ext;
    logic [IW-1:0]  ia_addr;
    logic           div_last;

    always_comb begin
        rem_sh   = {r_rem, r_dvd[PW-1]};
        ge       = rem_sh >= {1'b0, r_dvs};
        div_last = r_cnt == mbe_pkg::CNT_W'(PW - 1);
        k_ext    = mbe_pkg::TOP_W'(r_k);
        ia_addr  = IW'(r_top - k_ext);
        if (mbe_pkg::t_kind'(i_kind) == mbe_pkg::K_REP) begin
            top_c = mbe_pkg::TOP_W'(i_count_n) + mbe_pkg::TOP_W'(i_choose_k)
                    - mbe_pkg::TOP_W'(1);
        end else begin
            top_c = mbe_pkg::TOP_W'(i_count_n);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mbe_pkg::S_IDLE: begin
                if (i_valid) n_state = mbe_pkg::S_DECIDE;
            end
            mbe_pkg::S_DECIDE: begin
                if (r_zero) begin
                    n_state = mbe_pkg::S_OUT;
                end else if (mbe_pkg::t_kind'(r_kind) != mbe_pkg::K_FACT && k_ext > r_top) begin
                    n_state = mbe_pkg::S_OUT;
                end else if (r_top > mbe_pkg::TOP_W'(mbe_pkg::MAX_N)) begin
                    n_state = mbe_pkg::S_OUT;
                end else if (r_mod < VW'(2)) begin
                    n_state = mbe_pkg::S_OUT;
                end else if (mbe_pkg::TOP_W'(r_filled) > r_top) begin
                    n_state = mbe_pkg::S_QRD;
                end else begin
                    n_state = mbe_pkg::S_EXT;
                end
            end
            mbe_pkg::S_EXT: begin
                if (r_filled == '0) begin
                    n_state = (r_top == '0) ? mbe_pkg::S_QRD : mbe_pkg::S_EXT;
                end else if (r_filled == IW'(1)) begin
                    n_state = mbe_pkg::S_FAC;
                end else begin
                    n_state = mbe_pkg::S_DIV;
                end
            end
            mbe_pkg::S_DIV: begin
                if (div_last) n_state = r_ret;
            end
            mbe_pkg::S_INV_RD:  n_state = mbe_pkg::S_INV_MUL;
            mbe_pkg::S_INV_MUL: n_state = mbe_pkg::S_DIV;
            mbe_pkg::S_INV_WR:  n_state = mbe_pkg::S_FAC;
            mbe_pkg::S_FAC:     n_state = mbe_pkg::S_DIV;
            mbe_pkg::S_FAC_WR:  n_state = mbe_pkg::S_IFA;
            mbe_pkg::S_IFA:     n_state = mbe_pkg::S_DIV;
            mbe_pkg::S_IFA_WR: begin
                n_state = (mbe_pkg::TOP_W'(r_filled) == r_top) ? mbe_pkg::S_QRD
                                                               : mbe_pkg::S_EXT;
            end
            mbe_pkg::S_QRD:  n_state = mbe_pkg::S_QRD2;
            mbe_pkg::S_QRD2: n_state = mbe_pkg::S_QM1;
            mbe_pkg::S_QM1: begin
                n_state = (mbe_pkg::t_kind'(r_kind) == mbe_pkg::K_FACT) ? mbe_pkg::S_OUT
                                                                        : mbe_pkg::S_DIV;
            end
            mbe_pkg::S_QM2: begin
                n_state = (mbe_pkg::t_kind'(r_kind) == mbe_pkg::K_PERM) ? mbe_pkg::S_OUT
                                                                        : mbe_pkg::S_DIV;
            end
            mbe_pkg::S_QM3: n_state = mbe_pkg::S_OUT;
            mbe_pkg::S_OUT: begin
                if (i_ready) n_state = mbe_pkg::S_IDLE;
            end
            default: n_state = mbe_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready        = r_state == mbe_pkg::S_IDLE;
        o_valid        = r_state == mbe_pkg::S_OUT;
        o_value        = r_val;
        o_out_of_range = r_oor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mbe_pkg::S_IDLE;
            r_ret    <= mbe_pkg::S_IDLE;
            r_mod    <= mbe_pkg::MOD_RESET;
            r_filled <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mod    <= i_cfg_data;
                r_filled <= '0;
            end
            case (r_state)
                mbe_pkg::S_IDLE: begin
                    r_kind <= i_kind;
                    r_k    <= i_choose_k;
                    r_top  <= top_c;
                    r_zero <= mbe_pkg::t_kind'(i_kind) == mbe_pkg::K_REP
                              && i_count_n == '0 && i_choose_k == '0;
                end
                mbe_pkg::S_DECIDE: begin
                    r_val <= '0;
                    r_oor <= r_zero
                             || (!(mbe_pkg::t_kind'(r_kind) != mbe_pkg::K_FACT && k_ext > r_top)
                                 && r_top > mbe_pkg::TOP_W'(mbe_pkg::MAX_N));
                end
                mbe_pkg::S_EXT: begin
                    if (r_filled == '0) begin
                        inv_mem[r_filled] <= '0;
                        fac_mem[r_filled] <= VW'(1);
                        ifa_mem[r_filled] <= VW'(1);
                        r_flast  <= VW'(1);
                        r_iflast <= VW'(1);
                        r_filled <= IW'(1);
                    end else if (r_filled == IW'(1)) begin
                        inv_mem[r_filled] <= VW'(1);
                        r_inv <= VW'(1);
                    end else begin
                        r_dvd <= PW'(r_mod);
                        r_dvs <= VW'(r_filled);
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_ret <= mbe_pkg::S_INV_RD;
                    end
                end
                mbe_pkg::S_DIV: begin
                    r_rem <= ge ? VW'(rem_sh - {1'b0, r_dvs}) : VW'(rem_sh);
                    r_dvd <= {r_dvd[PW-2:0], ge};
                    r_cnt <= r_cnt + 1'b1;
                end
                mbe_pkg::S_INV_RD: begin
                    r_inv_q <= inv_mem[IW'(r_rem)];
                    r_q     <= r_dvd[VW-1:0];
                end
                mbe_pkg::S_INV_MUL: begin
                    r_dvd <= PW'(r_inv_q) * PW'(r_mod - r_q);
                    r_dvs <= r_mod;
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_ret <= mbe_pkg::S_INV_WR;
                end
                mbe_pkg::S_INV_WR: begin
                    inv_mem[r_filled] <= r_rem;
                    r_inv <= r_rem;
                end
                mbe_pkg::S_FAC: begin
                    r_dvd <= PW'(r_flast) * PW'(r_filled);
                    r_dvs <= r_mod;
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_ret <= mbe_pkg::S_FAC_WR;
                end
                mbe_pkg::S_FAC_WR: begin
                    fac_mem[r_filled] <= r_rem;
                    r_flast <= r_rem;
                end
                mbe_pkg::S_IFA: begin
                    r_dvd <= PW'(r_iflast) * PW'(r_inv);
                    r_dvs <= r_mod;
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_ret <= mbe_pkg::S_IFA_WR;
                end
                mbe_pkg::S_IFA_WR: begin
                    ifa_mem[r_filled] <= r_rem;
                    r_iflast <= r_rem;
                    r_filled <= r_filled + 1'b1;
                end
                mbe_pkg::S_QRD: begin
                    r_fq <= fac_mem[IW'(r_top)];
                    r_ia <= ifa_mem[ia_addr];
                end
                mbe_pkg::S_QRD2: begin
                    r_ib <= ifa_mem[IW'(r_k)];
                end
                mbe_pkg::S_QM1: begin
                    r_val <= r_fq;
                    r_dvd <= PW'(r_fq) * PW'(r_ia);
                    r_dvs <= r_mod;
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_ret <= mbe_pkg::S_QM2;
                end
                mbe_pkg::S_QM2: begin
                    r_val <= r_rem;
                    r_dvd <= PW'(r_rem) * PW'(r_ib);
                    r_dvs <= r_mod;
                    r_cnt <= '0;
                    r_rem <= '0;
                    r_ret <= mbe_pkg::S_QM3;
                end
                mbe_pkg::S_QM3: begin
                    r_val <= r_rem;
                end
                default: begin
                end
            endcase
        end
    end

endmodule
